### rtl/hsvd_pkg.sv
// shared constants and helper functions for the hsv brightness dimmer
`timescale 1ns / 1ps
package hsvd_pkg;
   localparam int unsigned COLOR_W = 24;
   localparam int unsigned Q_W     = 17;   // q1.16 value 0..65536
   localparam logic [16:0] Q_ONE   = 17'd65536;
   localparam logic [16:0] V_FLOOR = 17'd655;
   localparam logic [2:0]  LVL_MAX = 3'd4;
   localparam logic [1:0]  CSR_ADDR_LEVEL = 2'd0;

   function automatic logic [16:0] level_offset(input logic [2:0] lvl);
      logic [16:0] o;
      case (lvl)
         3'd0:    o = 17'd58982;
         3'd1:    o = 17'd45875;
         3'd2:    o = 17'd32768;
         3'd3:    o = 17'd19660;
         default: o = 17'd6553;
      endcase
      return o;
   endfunction

   // floor(x*255/65536)
   function automatic logic [7:0] to_channel(input logic [16:0] x);
      logic [24:0] m;
      m = {8'd0, x} * 25'd255;
      return m[23:16];
   endfunction
endpackage

### rtl/hsvd_stream_if.sv
// valid/ready stream interface carrying one packed colour
`timescale 1ns / 1ps
interface hsvd_stream_if;
   logic        valid;
   logic        ready;
   logic [23:0] color;
   modport source (output valid, output color, input ready);
   modport sink   (input valid, input color, output ready);
endinterface

### rtl/hsv_brightness_dimmer.sv
// top level of the hsv brightness dimmer
`timescale 1ns / 1ps
// Dims a packed rgb colour by lowering its hsv value by a fixed offset.
// req_ carries one colour per request (red 23:16, green 15:8, blue 7:0),
// rsp_ returns the dimmed colour in the same layout, black stays black.
// csr_ is an apb-style port; byte address 0 holds brightness_level
// (0 subtracts 0.9 ... 4 subtracts 0.1, 5..7 act as 4), reset value 3.
// A request enters every cycle unless the receiver stalls the pipeline;
// throughput is then one colour per cycle. From acceptance to rsp_valid a
// colour passes an input stage, the 27-stage bit-per-stage hue divider (the
// shorter saturation divider is padded to match), three math stages and the
// output register. The whole pipeline advances together; when the receiver
// holds rsp_ready low with a result waiting, the pipeline freezes and
// req_ready drops, so nothing is lost or repeated. Reset clears valid bits
// and sets the level register to 3.
module hsv_brightness_dimmer
   import hsvd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hsvd_stream_if.sink   req,
   hsvd_stream_if.source rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [2:0] level_ff;
   logic       advance;
   logic       out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 3'd3;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_LEVEL) begin
         level_ff <= csr_pwdata[2:0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_LEVEL) ? {29'd0, level_ff} : '0;

   assign advance   = !out_valid || rsp.ready;
   assign req.ready = advance;
   assign rsp.valid = out_valid;

   hsvd_core u_core (
      .clock, .reset, .advance,
      .in_valid(req.valid && advance),
      .color_in(req.color),
      .level(level_ff),
      .out_valid,
      .color_out(rsp.color));
endmodule

### rtl/hsvd_divider.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module hsvd_divider #(
   parameter int unsigned NUM_W = 19,
   parameter int unsigned DEN_W = 8,
   parameter int unsigned SIDE_W = 8
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num_in,
   input  logic [DEN_W-1:0]  den_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic [NUM_W-1:0]  quot_out,
   output logic [SIDE_W-1:0] side_out
);
   logic [DEN_W:0]    rem_ff  [1:NUM_W];
   logic [NUM_W-1:0]  num_ff  [1:NUM_W];
   logic [NUM_W-1:0]  quo_ff  [1:NUM_W];
   logic [DEN_W-1:0]  den_ff  [1:NUM_W];
   logic [SIDE_W-1:0] side_ff [1:NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_st
      logic [DEN_W:0]    rem_cur;
      logic [NUM_W-1:0]  num_cur, quo_cur;
      logic [DEN_W-1:0]  den_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [DEN_W+1:0]  sh_in;
      logic [DEN_W+1:0]  df_in;
      if (i == 0) begin : g_head
         assign rem_cur  = '0;
         assign num_cur  = num_in;
         assign quo_cur  = '0;
         assign den_cur  = den_in;
         assign side_cur = side_in;
      end else begin : g_body
         assign rem_cur  = rem_ff[i];
         assign num_cur  = num_ff[i];
         assign quo_cur  = quo_ff[i];
         assign den_cur  = den_ff[i];
         assign side_cur = side_ff[i];
      end
      always_comb begin
         sh_in = {rem_cur, num_cur[NUM_W-1-i]};
         df_in = sh_in - {2'b00, den_cur};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[i+1]  <= num_cur;
            den_ff[i+1]  <= den_cur;
            side_ff[i+1] <= side_cur;
            if (!df_in[DEN_W+1]) begin
               rem_ff[i+1] <= df_in[DEN_W:0];
               quo_ff[i+1] <= quo_cur | (NUM_W'(1) << (NUM_W-1-i));
            end else begin
               rem_ff[i+1] <= sh_in[DEN_W:0];
               quo_ff[i+1] <= quo_cur;
            end
         end
      end
   end

   assign quot_out = quo_ff[NUM_W];
   assign side_out = side_ff[NUM_W];
endmodule

### rtl/hsvd_core.sv
// pipelined rgb to hsv, value offset and hsv to rgb datapath
`timescale 1ns / 1ps
module hsvd_core
   import hsvd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [23:0] color_in,
   input  logic [2:0]  level,
   output logic        out_valid,
   output logic [23:0] color_out
);
   // input stage, 27 hue divider stages, three math stages, output register
   localparam int unsigned PIPE_LAT = 31;
   // side band: black, sector code 3, max 8, offset 17
   localparam int unsigned SIDE_W = 1 + 3 + 8 + 17;

   logic [7:0] r_w, g_w, b_w, mx_w, mn_w, dl_w;
   logic [2:0] base_w;
   logic [10:0] numer_w;
   logic [16:0] off_w;
   logic        black_w;

   always_comb begin
      r_w = color_in[23:16];
      g_w = color_in[15:8];
      b_w = color_in[7:0];
      black_w = (color_in == '0);
      off_w = level_offset((level > LVL_MAX) ? LVL_MAX : level);
      if (r_w >= g_w && r_w >= b_w) begin
         mx_w = r_w; mn_w = (g_w < b_w) ? g_w : b_w;
      end else if (g_w >= b_w) begin
         mx_w = g_w; mn_w = (r_w < b_w) ? r_w : b_w;
      end else begin
         mx_w = b_w; mn_w = (r_w < g_w) ? r_w : g_w;
      end
      dl_w = mx_w - mn_w;
      if (mx_w == r_w) begin
         if (g_w >= b_w) numer_w = {3'd0, g_w - b_w};
         else numer_w = 11'd6 * {3'd0, dl_w} - {3'd0, b_w - g_w};
      end else if (mx_w == g_w) begin
         numer_w = 11'd2 * {3'd0, dl_w} + {3'd0, b_w} - {3'd0, r_w};
      end else begin
         numer_w = 11'd4 * {3'd0, dl_w} + {3'd0, r_w} - {3'd0, g_w};
      end
      if (dl_w == '0) numer_w = '0;
   end

   // stage 1 registers feed the dividers
   logic [26:0] hnum_ff;
   logic [7:0]  dl_ff, mx_ff;
   logic [SIDE_W-1:0] side1_ff;
   logic [PIPE_LAT:0] vld_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hnum_ff  <= {numer_w, 16'd0};
         dl_ff    <= dl_w;
         mx_ff    <= mx_w;
         side1_ff <= {black_w, 3'd0, mx_w, off_w};
      end
   end

   logic [26:0] hpos_w;
   logic [24:0] sq_w;
   logic [SIDE_W-1:0] side_d_w, side_unused_w;

   // grey: delta zero gives quotient all ones, masked below
   hsvd_divider #(.NUM_W(27), .DEN_W(8), .SIDE_W(SIDE_W)) u_hue (
      .clock, .advance,
      .num_in(hnum_ff), .den_in(dl_ff), .side_in(side1_ff),
      .quot_out(hpos_w), .side_out(side_d_w));
   logic [8:0] dz_unused_w;
   hsvd_divider #(.NUM_W(25), .DEN_W(8), .SIDE_W(SIDE_W + 9)) u_sat (
      .clock, .advance,
      .num_in({1'b0, dl_ff, 16'd0}), .den_in(mx_ff),
      .side_in({side1_ff, dl_ff == '0, dl_ff}),
      .quot_out(sq_w), .side_out({side_unused_w, dz_unused_w}));
   // two delay registers pad the shorter saturation divider to the hue divider
   logic [16:0] s_d1_ff, s_d2_ff;
   logic        gz_d1_ff, gz_d2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s_d1_ff  <= (sq_w[16:0] > Q_ONE || dz_unused_w[8]) ? '0 : sq_w[16:0];
         gz_d1_ff <= dz_unused_w[8];
         s_d2_ff  <= s_d1_ff;
         gz_d2_ff <= gz_d1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[PIPE_LAT-1:0], in_valid};
   end

   // stage a: sector, frac, value (v=floor(mx*65536/255) by table-free reciprocal)
   logic [2:0]  sec_w;
   logic [15:0] frac_w;
   logic [7:0]  mxd_w;
   logic [16:0] offd_w, v_w;
   logic [24:0] vmul_w;
   logic [17:0] vsub_w;
   always_comb begin
      mxd_w  = side_d_w[24:17];
      offd_w = side_d_w[16:0];
      frac_w = gz_d2_ff ? 16'd0 : hpos_w[15:0];
      // hue position stays below twelve sectors, one compare folds it
      sec_w  = gz_d2_ff ? 3'd0 :
               ((hpos_w[26:16] >= 11'd6) ? 3'(hpos_w[26:16] - 11'd6) : hpos_w[18:16]);
      // mx*65536/255 = mx*257 + mx/255; the floor adds one only when mx*257 is 0xffff
      vmul_w = {17'd0, mxd_w} * 25'd257;
      v_w    = vmul_w[16:0] + 17'(vmul_w[24:16]) + 17'(((vmul_w[15:0] + 16'(vmul_w[24:16])) == 16'hffff) ? 1 : 0) ;
      vsub_w = {1'b0, v_w} - {1'b0, offd_w};
   end

   logic [16:0] va_ff, sa_ff;
   logic [15:0] fa_ff;
   logic [2:0]  seca_ff;
   logic        blka_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         va_ff   <= vsub_w[17] ? V_FLOOR : vsub_w[16:0];
         sa_ff   <= s_d2_ff;
         fa_ff   <= frac_w;
         seca_ff <= sec_w;
         blka_ff <= side_d_w[SIDE_W-1];
      end
   end

   // stage b: f*s and (1-f)*s, registered as factors 1-s, 1-f*s and 1-(1-f)*s
   logic [33:0] fs_w, gs_w;
   always_comb begin
      fs_w = {18'd0, fa_ff} * {17'd0, sa_ff};
      gs_w = (34'(Q_ONE) - {18'd0, fa_ff}) * {17'd0, sa_ff};
   end
   logic [16:0] vb_ff, pm_ff, qm_ff, tm_ff;
   logic [2:0]  secb_ff;
   logic        blkb_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         vb_ff   <= va_ff;
         pm_ff   <= Q_ONE - sa_ff;
         qm_ff   <= Q_ONE - fs_w[32:16];
         tm_ff   <= Q_ONE - gs_w[32:16];
         secb_ff <= seca_ff;
         blkb_ff <= blka_ff;
      end
   end

   // stage c: v times each factor
   logic [33:0] pp_w, qp_w, tp_w;
   always_comb begin
      pp_w = {17'd0, vb_ff} * {17'd0, pm_ff};
      qp_w = {17'd0, vb_ff} * {17'd0, qm_ff};
      tp_w = {17'd0, vb_ff} * {17'd0, tm_ff};
   end
   logic [16:0] vc_ff, pc_ff, qc_ff, tc_ff;
   logic [2:0]  secc_ff;
   logic        blkc_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         vc_ff <= vb_ff;
         pc_ff <= pp_w[32:16];
         qc_ff <= qp_w[32:16];
         tc_ff <= tp_w[32:16];
         secc_ff <= secb_ff;
         blkc_ff <= blkb_ff;
      end
   end

   // stage d: channel scaling and sector select
   logic [7:0] cv_w, cp_w, cq_w, ct_w;
   logic [23:0] rgb_w;
   always_comb begin
      cv_w = to_channel(vc_ff);
      cp_w = to_channel(pc_ff);
      cq_w = to_channel(qc_ff);
      ct_w = to_channel(tc_ff);
      case (secc_ff)
         3'd0:    rgb_w = {cv_w, ct_w, cp_w};
         3'd1:    rgb_w = {cq_w, cv_w, cp_w};
         3'd2:    rgb_w = {cp_w, cv_w, ct_w};
         3'd3:    rgb_w = {cp_w, cq_w, cv_w};
         3'd4:    rgb_w = {ct_w, cp_w, cv_w};
         default: rgb_w = {cv_w, cp_w, cq_w};
      endcase
   end
   logic [23:0] out_ff;
   always_ff @(posedge clock) begin
      if (advance) out_ff <= blkc_ff ? '0 : rgb_w;
   end

   assign color_out = out_ff;
   assign out_valid = vld_ff[PIPE_LAT];
endmodule

### test/testbench.sv
// self-checking testbench for the hsv brightness dimmer
`timescale 1ns / 1ps
module testbench;
   import hsvd_pkg::*;

   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   hsvd_stream_if req_if ();
   hsvd_stream_if rsp_if ();

   hsv_brightness_dimmer u_top (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [23:0] color_pending[$];
   logic [23:0] dimmed_expected[$];
   logic [2:0]  level_copy;
   int          send_idle_pct, recv_stall_pct;
   int          hold_cycles;
   bit          long_hold_ask;
   bit          req_taken;
   int          error_count, request_count, result_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // value offsets in q0.16 per level, levels above four act as four
   function automatic logic [63:0] level_to_offset(input logic [2:0] lvl);
      case (lvl)
         3'd0:    return 64'd58982;
         3'd1:    return 64'd45875;
         3'd2:    return 64'd32768;
         3'd3:    return 64'd19660;
         default: return 64'd6553;
      endcase
   endfunction

   function automatic logic [7:0] q16_to_byte(input logic [63:0] x);
      logic [63:0] m;
      m = (x * 64'd255) >> 16;
      return m[7:0];
   endfunction

   function automatic logic [23:0] dimmed_color(input logic [23:0] c, input logic [2:0] lvl);
      logic [63:0] r, g, b, mx, mn, delta, numer, hpos, sat, val, off;
      logic [63:0] frac, sector, p, q, t;
      logic [7:0]  ro, go, bo;
      r = 64'(c[23:16]);
      g = 64'(c[15:8]);
      b = 64'(c[7:0]);
      sector = 0;
      frac = 0;
      sat = 0;
      numer = 0;
      if (c == 24'd0) return 24'd0;
      if (r >= g && r >= b) begin
         mx = r; mn = (g < b) ? g : b;
      end else if (g >= r && g >= b) begin
         mx = g; mn = (r < b) ? r : b;
      end else begin
         mx = b; mn = (r < g) ? r : g;
      end
      delta = mx - mn;
      if (delta != 0) begin
         if (mx == r) begin
            if (g >= b) numer = g - b;
            else numer = 6 * delta - (b - g);
         end else if (mx == g) begin
            numer = 2 * delta + b - r;
         end else begin
            numer = 4 * delta + r - g;
         end
         hpos = (numer << 16) / delta;
         sector = (hpos >> 16) % 6;
         frac = hpos & 64'hFFFF;
      end
      if (mx != 0) sat = (delta << 16) / mx;
      val = (mx << 16) / 255;
      off = level_to_offset(lvl);
      // negative value clamps to 0.01, exact zero stays zero
      if (val < off) val = 64'd655;
      else val = val - off;
      p = (val * (64'd65536 - sat)) >> 16;
      q = (val * (64'd65536 - ((frac * sat) >> 16))) >> 16;
      t = (val * (64'd65536 - (((64'd65536 - frac) * sat) >> 16))) >> 16;
      case (sector)
         0: begin ro = q16_to_byte(val); go = q16_to_byte(t); bo = q16_to_byte(p); end
         1: begin ro = q16_to_byte(q); go = q16_to_byte(val); bo = q16_to_byte(p); end
         2: begin ro = q16_to_byte(p); go = q16_to_byte(val); bo = q16_to_byte(t); end
         3: begin ro = q16_to_byte(p); go = q16_to_byte(q); bo = q16_to_byte(val); end
         4: begin ro = q16_to_byte(t); go = q16_to_byte(p); bo = q16_to_byte(val); end
         default: begin ro = q16_to_byte(val); go = q16_to_byte(p); bo = q16_to_byte(q); end
      endcase
      return {ro, go, bo};
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.color <= 24'd0;
      end else if (!req_if.valid || req_taken) begin
         if (color_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.color <= color_pending.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver with its own long hold-off counter
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= 0;
      end else if (long_hold_ask) begin
         long_hold_ask <= 1'b0;
         hold_cycles <= 300;
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            dimmed_expected.push_back(dimmed_color(req_if.color, level_copy));
            request_count++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_count++;
            if (dimmed_expected.size() == 0) begin
               $error("color_out unexpected result %06h", rsp_if.color);
               error_count++;
            end else begin
               logic [23:0] want;
               want = dimmed_expected.pop_front();
               if (rsp_if.color !== want) begin
                  $error("color_out expected %06h got %06h", want, rsp_if.color);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic write_level(input logic [2:0] lvl);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_penable = 1'b0;
      csr_paddr = CSR_ADDR_LEVEL; csr_pwdata = {29'd0, lvl};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      level_copy = lvl;
   endtask

   task automatic wait_drained();
      wait (color_pending.size() == 0 && !req_if.valid);
      wait (dimmed_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   logic [2:0] phase_levels[8] = '{3'd3, 3'd0, 3'd4, 3'd7, 3'd1, 3'd2, 3'd5, 3'd6};
   int idle_modes[4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{9, 9}};

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      send_idle_pct = 0; recv_stall_pct = 0;
      long_hold_ask = 1'b0;
      level_copy = 3'd3;
      error_count = 0; request_count = 0; result_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed colors at the reset level: black, white, primaries, greys, edges
      color_pending = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                        24'h808080, 24'h010101, 24'h000001, 24'h010000, 24'hFFFF00,
                        24'h00FFFF, 24'hFF00FF, 24'hFFFFFE, 24'hFE00FF, 24'hFF00FE,
                        24'h123456, 24'hAAAAAA, 24'h555555, 24'h0F0F0F, 24'hFF8000};
      wait_drained();
      // colors at the strongest offset; the dark ones clamp to the floor
      write_level(3'd0);
      color_pending = '{24'h010203, 24'h200000, 24'h00F000, 24'hE6E6E6, 24'hFFFFFF};
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         write_level(phase_levels[ph]);
         send_idle_pct = idle_modes[ph % 4][0];
         recv_stall_pct = idle_modes[ph % 4][1];
         for (int n = 0; n < 185; n++) begin
            if ($urandom_range(1)) color_pending.push_back(24'($urandom_range(24'hFFFFFF)));
            else color_pending.push_back({pick_channel(), pick_channel(), pick_channel()});
         end
         if (ph == 2) begin
            // receiver holds off long enough to back the pipeline up
            wait (color_pending.size() < 150);
            long_hold_ask = 1'b1;
         end
         if (ph == 5) begin
            // sender pause until all results are back
            wait (color_pending.size() < 90);
            send_idle_pct = 100;
            wait (dimmed_expected.size() == 0);
            send_idle_pct = idle_modes[ph % 4][0];
         end
         wait_drained();
      end

      $display("covered %0d requests and %0d results over levels 0..7", request_count,
               result_count);
      $display("with sender gaps, receiver stalls and a long receiver hold-off");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule

### files.f
rtl/hsvd_pkg.sv
rtl/hsvd_stream_if.sv
rtl/hsvd_divider.sv
rtl/hsvd_core.sv
rtl/hsv_brightness_dimmer.sv
test/testbench.sv
